// ===== hw/rtl/tlb_pkg.sv =====
// tlb_pkg: shared types, constants and defaults for the page table translate block
// no dependencies
package tlb_pkg;
  localparam int TLB_ENTRIES_D = 16;
  localparam int PAGE_COUNT_D  = 256;
  localparam int FRAME_COUNT_D = 256;
  localparam int PAGE_BYTES_D  = 256;
  localparam int VA_W   = 16;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 32;

  typedef enum logic {
    OP_READ = 1'b0,
    OP_MAP  = 1'b1
  } op_t;

  typedef struct packed {
    logic                     op;
    logic [VA_W-1:0]          virt_addr;
    logic [VA_W-1:0]          phys_addr;
    logic signed [DATA_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     page_fault;
    logic                     tlb_hit;
    logic [CNT_W-1:0]         hit_total;
    logic [CNT_W-1:0]         miss_total;
    logic [CNT_W-1:0]         fault_total;
  } rsp_t;
endpackage

// ===== hw/rtl/tlb_if.sv =====
// tlb_if: valid/ready channel carrying one beat of a payload type
// depends on tlb_pkg for the payload types
interface tlb_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tlb_ram.sv =====
// tlb_ram: generic single port write, single port read ram with registered read
// no dependencies
module tlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/tlb_queue.sv =====
// tlb_queue: two entry beat queue between front and back
// depends on tlb_pkg
module tlb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tlb_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tlb_pkg::req_t out_data
);
  import tlb_pkg::*;
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== hw/rtl/tlb_back.sv =====
// tlb_back: tlb search, page table and byte store access, counters, result register
// depends on tlb_pkg and tlb_ram; the byte store is cleared by a sweep after reset
module tlb_back #(
  parameter int TLB_ENTRIES = tlb_pkg::TLB_ENTRIES_D,
  parameter int PAGE_COUNT  = tlb_pkg::PAGE_COUNT_D,
  parameter int FRAME_COUNT = tlb_pkg::FRAME_COUNT_D,
  parameter int PAGE_BYTES  = tlb_pkg::PAGE_BYTES_D
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tlb_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tlb_pkg::rsp_t out_data,
  output logic          clearing
);
  import tlb_pkg::*;
  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int SD = FRAME_COUNT * PAGE_BYTES;
  localparam int SW = $clog2(SD);
  localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CW = $clog2(TLB_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_PT   = 5'b00100,
    S_RD   = 5'b01000,
    S_OUT  = 5'b10000
  } st_t;

  st_t              st_r, st_nxt;
  req_t             req_r;
  logic [PW-1:0]    tpage_r [TLB_ENTRIES];
  logic [FW-1:0]    tframe_r [TLB_ENTRIES];
  logic [CW-1:0]    fill_r;
  logic [TW-1:0]    next_r;
  logic [PAGE_COUNT-1:0] mvalid_r;
  logic [CNT_W-1:0] hit_r, miss_r, fault_r;
  logic [SW-1:0]    clr_r;
  logic             hit_r1, fault_r1;
  logic [FW-1:0]    frame_r;
  rsp_t             rsp_r;
  logic             out_valid_r;

  logic [VA_W-1:0]  pg_wide;
  logic [PW-1:0]    pg;
  logic [OW-1:0]    off;
  logic             found;
  logic [FW-1:0]    found_frame;
  logic [FW-1:0]    pt_rdata;
  logic [FW-1:0]    rd_frame;
  logic [DATA_W-1:0] st_rdata;
  logic             pt_we, st_we;
  logic [SW-1:0]    st_waddr, st_raddr;
  logic [DATA_W-1:0] st_wdata;
  logic             rsp_load;

  assign pg_wide = req_r.virt_addr >> OW;
  assign pg  = pg_wide[PW-1:0];
  assign off = req_r.virt_addr[OW-1:0];

  always_comb begin
    found = 1'b0;
    found_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if ((CW'(i) < fill_r) && (tpage_r[i] == pg)) begin
        found = 1'b1;
        found_frame = tframe_r[i];
      end
    end
  end

  assign pt_we = in_valid && in_ready && (in_data.op == OP_MAP);
  tlb_ram #(.WIDTH(FW), .DEPTH(PAGE_COUNT)) u_pt (
    .clk(clk), .we(pt_we),
    .waddr(PW'(in_data.virt_addr >> OW)),
    .wdata(FW'(in_data.phys_addr >> OW)),
    .raddr(pg), .rdata(pt_rdata)
  );

  // on a miss the frame comes straight from the page table read
  assign rd_frame = (st_r == S_RD && !hit_r1) ? pt_rdata : frame_r;
  assign st_we    = (st_r == S_CLR) || pt_we;
  assign st_waddr = (st_r == S_CLR) ? clr_r : SW'(in_data.phys_addr);
  assign st_wdata = (st_r == S_CLR) ? '0 : in_data.write_value;
  assign st_raddr = {rd_frame, off};
  tlb_ram #(.WIDTH(DATA_W), .DEPTH(SD)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  assign in_ready  = (st_r == S_IDLE);
  assign rsp_load  = (st_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = rsp_r;
  assign clearing  = (st_r == S_CLR);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (&c) ? c : c + CNT_W'(1);
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR:  if (clr_r == SW'(SD - 1)) st_nxt = S_IDLE;
      S_IDLE: if (in_valid && in_ready) st_nxt = (in_data.op == OP_MAP) ? S_OUT : S_PT;
      S_PT:   st_nxt = S_RD;
      S_RD:   st_nxt = S_OUT;
      S_OUT:  if (rsp_load) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((st_r == S_IDLE) && in_valid && in_ready) req_r <= in_data;
    if (st_r == S_PT) begin
      hit_r1   <= found;
      fault_r1 <= !found && !mvalid_r[pg];
      frame_r  <= found ? found_frame : frame_r;
    end
    if (st_r == S_RD && !hit_r1 && !fault_r1) begin
      tpage_r[next_r]  <= pg;
      tframe_r[next_r] <= pt_rdata;
      frame_r          <= pt_rdata;
    end
    if (rsp_load) begin
      rsp_r.page_fault  <= (req_r.op == OP_READ) && fault_r1;
      rsp_r.tlb_hit     <= (req_r.op == OP_READ) && hit_r1;
      rsp_r.read_data   <= (req_r.op == OP_READ && !fault_r1) ? st_rdata : '0;
      rsp_r.hit_total   <= hit_r;
      rsp_r.miss_total  <= miss_r;
      rsp_r.fault_total <= fault_r;
    end
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; fill_r <= '0; next_r <= '0;
      mvalid_r <= '0; hit_r <= '0; miss_r <= '0; fault_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + SW'(1);
      if (pt_we) mvalid_r[PW'(in_data.virt_addr >> OW)] <= 1'b1;
      if (st_r == S_PT) begin
        if (found) begin
          hit_r <= sat_inc(hit_r);
        end else begin
          miss_r <= sat_inc(miss_r);
          if (!mvalid_r[pg]) fault_r <= sat_inc(fault_r);
        end
      end
      if (st_r == S_RD && !hit_r1 && !fault_r1) begin
        next_r <= (next_r == TW'(TLB_ENTRIES - 1)) ? '0 : next_r + TW'(1);
        if (fill_r != CW'(TLB_ENTRIES)) fill_r <= fill_r + CW'(1);
      end
      if (rsp_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end
endmodule

// ===== hw/rtl/tlb_page_table_translate.sv =====
// tlb_page_table_translate: top level, input queue in front of the translate back end
// depends on tlb_pkg, tlb_if, tlb_queue, tlb_back, tlb_ram
// A lookup beat passes the back end steps accept, tlb compare with page table read,
// byte store read and result register, and a map beat the steps accept with the writes
// and result register; the result waits in an output register, so the back end takes its
// next beat while the result is still offered, and a two entry queue in front keeps
// accepting. A result that is not taken holds the back end in its result state. After
// reset the byte store is cleared one byte a cycle, all FRAME_COUNT*PAGE_BYTES bytes
// (65536 by default), before beats move. The TLB is not flushed on remap: a stale
// entry still hits.
module tlb_page_table_translate #(
  parameter int TLB_ENTRIES = tlb_pkg::TLB_ENTRIES_D,
  parameter int PAGE_COUNT  = tlb_pkg::PAGE_COUNT_D,
  parameter int FRAME_COUNT = tlb_pkg::FRAME_COUNT_D,
  parameter int PAGE_BYTES  = tlb_pkg::PAGE_BYTES_D
) (
  input logic clk,
  input logic rst_n,
  tlb_if.sink   in_ch,
  tlb_if.source out_ch
);
  import tlb_pkg::*;
  logic q_valid, q_ready, clearing;
  req_t q_data;

  tlb_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  tlb_back #(
    .TLB_ENTRIES(TLB_ENTRIES), .PAGE_COUNT(PAGE_COUNT),
    .FRAME_COUNT(FRAME_COUNT), .PAGE_BYTES(PAGE_BYTES)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .clearing(clearing)
  );

  a_no_take_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_ready) else $error("back end took a beat during clear");
  a_fault_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.data.page_fault && out_ch.data.tlb_hit))
    else $error("fault and hit together");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.page_fault) |-> (out_ch.data.read_data == 0))
    else $error("fault with data");
endmodule
